// File: hdl/failure_breaker_table_defines.svh
// Assertion macros shared by the failure breaker table RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef FAILURE_BREAKER_TABLE_DEFINES_SVH
`define FAILURE_BREAKER_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold after the antecedent rather than with it.
`define FBT_ASSERT_LATER2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// File: hdl/fbt_pkg.sv
// Package of the failure breaker table: widths, action and status codes,
// entry and table access types, and saturating counter helpers. No dependencies.
`default_nettype none

package fbt_pkg;

  localparam int TARGETS_DEF = 8;
  localparam int MODELS_DEF  = 4;

  localparam int RUN_W   = 16;
  localparam int TOTAL_W = 32;
  localparam int TIME_W  = 40;
  localparam int HINT_W  = 22;
  localparam int THR_W   = 8;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd3;
  localparam logic [HINT_W-1:0] COOLDOWN_RST  = 22'd30000;

  // Register indexes on the configuration port (address bit 2).
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_COOLDOWN  = 1'b1;

  localparam logic [1:0] ST_HEALTHY  = 2'd0;
  localparam logic [1:0] ST_DEGRADED = 2'd1;
  localparam logic [1:0] ST_OPEN     = 2'd2;

  typedef enum logic [2:0] {
    ACT_TARGET_FAIL    = 3'd0,
    ACT_MODEL_FAIL     = 3'd1,
    ACT_TARGET_SUCCESS = 3'd2,
    ACT_MODEL_SUCCESS  = 3'd3,
    ACT_QUERY          = 3'd4,
    ACT_FORGET         = 3'd5,
    ACT_CLEAR_ALL      = 3'd6
  } action_e;

  typedef struct packed {
    logic [RUN_W-1:0]   run;
    logic [TOTAL_W-1:0] total;
    logic [TIME_W-1:0]  expiry;
    logic [1:0]         st;
  } fbt_entry_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [HINT_W-1:0] cooldown;
  } fbt_cfg_t;

  typedef struct packed {
    logic       clear_all;
    logic       forget;
    logic       tgt_we;
    logic       mdl_we;
    fbt_entry_t tgt;
    fbt_entry_t mdl;
  } fbt_wr_t;

  typedef struct packed {
    fbt_entry_t tgt;
    fbt_entry_t mdl;
    logic       present;
    logic       any_present;
  } fbt_rd_t;

  function automatic logic [RUN_W-1:0] inc_run(input logic [RUN_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] inc_total(input logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// File: hdl/failure_breaker_table.sv
// Failure breaker table, top level. Depends on fbt_pkg, fbt_apb_regs, fbt_fail_calc, fbt_table.
// A word taken at a clock edge passes the input register and then the result register, and
// its result then stands on the result ports with done_o high.
// Throughput: one word per cycle; the state table is read combinationally and rewritten
// as the result loads. Busy is never raised and results cannot be held off.
// Reset clears every breaker entry and presence flag and loads the register defaults at
// once; no clearing pass follows, so the block takes words from the first edge after reset.
`default_nettype none
`include "failure_breaker_table_defines.svh"

module failure_breaker_table import fbt_pkg::*; #(
  parameter int TARGETS           = TARGETS_DEF,
  parameter int MODELS_PER_TARGET = MODELS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Command channel.
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          action_i,
  input  wire logic [2:0]          target_index_i,
  input  wire logic [1:0]          model_index_i,
  input  wire logic [TIME_W-1:0]   now_ms_i,
  input  wire logic [HINT_W-1:0]   hint_ms_i,
  // Result channel.
  output logic                     done_o,
  output logic                     skipped_o,
  output logic                     model_open_o,
  output logic                     target_open_o,
  output logic [RUN_W-1:0]         target_run_o,
  output logic [RUN_W-1:0]         model_run_o,
  output logic [TOTAL_W-1:0]       target_total_o,
  output logic [TOTAL_W-1:0]       model_total_o,
  output logic [1:0]               target_status_o,
  output logic [1:0]               model_status_o,
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int TIDX_W = (TARGETS > 1) ? $clog2(TARGETS) : 1;
  localparam int KIDX_W = (TARGETS * MODELS_PER_TARGET > 1) ?
                          $clog2(TARGETS * MODELS_PER_TARGET) : 1;

  // The block never stalls the command side.
  assign busy = 1'b0;

  fbt_cfg_t cfg;

  fbt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input register: the accepted command word waits here while the table is
  // read and rewritten at its indices.
  // ---------------------------------------------------------------------------
  logic              item_valid_q;
  action_e           action_q;
  logic [2:0]        target_q;
  logic [1:0]        model_q;
  logic [TIME_W-1:0] now_q;
  logic [HINT_W-1:0] hint_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start & ~busy) begin
      action_q <= action_e'(action_i);
      target_q <= target_index_i;
      model_q  <= model_index_i;
      now_q    <= now_ms_i;
      hint_q   <= hint_ms_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Index decode. A target beyond the table ignores the word (only clear-all
  // still acts); a model slot beyond the target's slots makes the model part
  // absent. Out-of-range words read entry zero, whose data is then masked.
  // ---------------------------------------------------------------------------
  logic              t_ok;
  logic              m_ok;
  logic [TIDX_W-1:0] t_idx;
  logic [KIDX_W-1:0] k_idx;

  assign t_ok  = 32'(target_q) < 32'(TARGETS);
  assign m_ok  = t_ok && (32'(model_q) < 32'(MODELS_PER_TARGET));
  assign t_idx = t_ok ? TIDX_W'(target_q) : '0;
  assign k_idx = m_ok ? KIDX_W'(32'(t_idx) * MODELS_PER_TARGET + 32'(model_q)) : '0;

  fbt_wr_t    wr;
  fbt_rd_t    rd;
  fbt_entry_t fail_in;
  fbt_entry_t fail_out;

  fbt_table #(
    .TARGETS           (TARGETS),
    .MODELS_PER_TARGET (MODELS_PER_TARGET),
    .TIDX_W            (TIDX_W),
    .KIDX_W            (KIDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .t_idx_i (t_idx),
    .k_idx_i (k_idx),
    .wr_i    (wr),
    .rd_o    (rd)
  );

  // One failure unit serves both kinds of failure: a model failure feeds it the
  // model entry, every other word the target entry.
  assign fail_in = (action_q == ACT_MODEL_FAIL) ? rd.mdl : rd.tgt;

  fbt_fail_calc u_fail (
    .entry_i (fail_in),
    .now_i   (now_q),
    .hint_i  (hint_q),
    .cfg_i   (cfg),
    .entry_o (fail_out)
  );

  // ---------------------------------------------------------------------------
  // Write-back decision and the state as it stands after this word.
  // ---------------------------------------------------------------------------
  fbt_entry_t tgt_post;
  fbt_entry_t mdl_post;
  fbt_entry_t tgt_ok_entry;
  logic       pres_post;
  logic       act_en;

  assign act_en = item_valid_q & t_ok;

  // A success keeps the total but closes the window and clears the run.
  assign tgt_ok_entry = '{run: '0, total: rd.tgt.total, expiry: '0, st: ST_HEALTHY};

  always_comb begin
    wr = '0;
    wr.clear_all = item_valid_q && (action_q == ACT_CLEAR_ALL);
    case (action_q)
      ACT_TARGET_FAIL: begin
        wr.tgt_we = act_en;
        wr.tgt    = fail_out;
      end
      ACT_MODEL_FAIL: begin
        // The target entry mirrors the model's run, status and window and
        // counts the failure in its own total.
        wr.mdl_we = act_en & m_ok;
        wr.mdl    = fail_out;
        wr.tgt_we = act_en & m_ok;
        wr.tgt    = '{run: fail_out.run, total: inc_total(rd.tgt.total),
                      expiry: fail_out.expiry, st: fail_out.st};
      end
      ACT_TARGET_SUCCESS: begin
        wr.tgt_we = act_en;
        wr.tgt    = tgt_ok_entry;
      end
      ACT_MODEL_SUCCESS: begin
        wr.mdl_we = act_en & m_ok;
        wr.mdl    = '{run: '0, total: rd.mdl.total, expiry: '0, st: ST_HEALTHY};
        wr.tgt_we = act_en & m_ok;
        wr.tgt    = tgt_ok_entry;
      end
      ACT_FORGET: begin
        wr.forget = act_en;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (wr.clear_all || wr.forget) begin
      tgt_post  = '0;
      mdl_post  = '0;
      pres_post = 1'b0;
    end else begin
      tgt_post  = wr.tgt_we ? wr.tgt : rd.tgt;
      mdl_post  = wr.mdl_we ? wr.mdl : rd.mdl;
      pres_post = rd.present | wr.mdl_we;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic              t_open;
  logic              m_open;
  logic              skip;

  logic              done_q;
  logic              skipped_q, model_open_q, target_open_q;
  logic [RUN_W-1:0]  target_run_q, model_run_q;
  logic [TOTAL_W-1:0] target_total_q, model_total_q;
  logic [1:0]        target_status_q, model_status_q;

  assign t_open = t_ok && (now_q < tgt_post.expiry);
  assign m_open = m_ok && pres_post && (now_q < mdl_post.expiry);
  // A query skips when the model window runs, or when the target window runs
  // and the target has never seen a model word.
  assign skip   = (action_q == ACT_QUERY) && (m_open || (!rd.any_present && t_open));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_q) begin
      skipped_q       <= skip;
      model_open_q    <= m_open;
      target_open_q   <= t_open;
      target_run_q    <= t_ok ? tgt_post.run : '0;
      target_total_q  <= t_ok ? tgt_post.total : '0;
      target_status_q <= t_ok ? tgt_post.st : ST_HEALTHY;
      model_run_q     <= m_ok ? mdl_post.run : '0;
      model_total_q   <= m_ok ? mdl_post.total : '0;
      model_status_q  <= m_ok ? mdl_post.st : ST_HEALTHY;
    end
  end

  assign done_o          = done_q;
  assign skipped_o       = skipped_q;
  assign model_open_o    = model_open_q;
  assign target_open_o   = target_open_q;
  assign target_run_o    = target_run_q;
  assign model_run_o     = model_run_q;
  assign target_total_o  = target_total_q;
  assign model_total_o   = model_total_q;
  assign target_status_o = target_status_q;
  assign model_status_o  = model_status_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `FBT_ASSERT_LATER2(a_result_follows, start && !busy, done_o, "accepted word gave no result")
  `FBT_ASSERT_SAME(a_skip_needs_window, done_o && skipped_o, model_open_o || target_open_o, "skip without open window")
  `FBT_ASSERT_SAME(a_topen_has_failures, done_o && target_open_o, target_total_o != '0, "target window open without failures")
  `FBT_ASSERT_SAME(a_mopen_has_failures, done_o && model_open_o, model_total_o != '0, "model window open without failures")

endmodule

`default_nettype wire

// File: hdl/fbt_apb_regs.sv
// Configuration registers of the failure breaker table behind an APB-style port.
// Depends on fbt_pkg.
`default_nettype none

module fbt_apb_regs import fbt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output fbt_cfg_t         cfg_o
);

  logic [THR_W-1:0]  threshold_q, threshold_d;
  logic [HINT_W-1:0] cooldown_q, cooldown_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    threshold_d = threshold_q;
    cooldown_d  = cooldown_q;
    if (wr_en) begin
      if (paddr[2] == REG_THRESHOLD) begin
        threshold_d = pwdata[THR_W-1:0];
      end else begin
        cooldown_d = pwdata[HINT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      cooldown_q  <= COOLDOWN_RST;
    end else begin
      threshold_q <= threshold_d;
      cooldown_q  <= cooldown_d;
    end
  end

  assign prdata = (paddr[2] == REG_COOLDOWN) ? {{(32-HINT_W){1'b0}}, cooldown_q}
                                             : {{(32-THR_W){1'b0}}, threshold_q};

  assign cfg_o.threshold = threshold_q;
  assign cfg_o.cooldown  = cooldown_q;

endmodule

`default_nettype wire

// File: hdl/fbt_fail_calc.sv
// Failure update of one breaker entry: counts, trip decision and window end.
// Depends on fbt_pkg.
`default_nettype none

module fbt_fail_calc import fbt_pkg::*; (
  input  wire fbt_entry_t         entry_i,
  input  wire logic [TIME_W-1:0]  now_i,
  input  wire logic [HINT_W-1:0]  hint_i,
  input  wire fbt_cfg_t           cfg_i,
  output fbt_entry_t              entry_o
);

  logic [RUN_W-1:0]  run_inc;
  logic              trip;
  logic [HINT_W-1:0] wait_ms;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] win_end;

  assign run_inc = inc_run(entry_i.run);
  assign trip    = (hint_i != '0) || (run_inc >= {{(RUN_W-THR_W){1'b0}}, cfg_i.threshold});
  assign wait_ms = (cfg_i.cooldown > hint_i) ? cfg_i.cooldown : hint_i;
  assign sum     = {1'b0, now_i} + {{(TIME_W+1-HINT_W){1'b0}}, wait_ms};
  // The window end holds at the largest time rather than wrapping.
  assign win_end = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  assign entry_o.run    = run_inc;
  assign entry_o.total  = inc_total(entry_i.total);
  assign entry_o.st     = trip ? ST_OPEN : ST_DEGRADED;
  assign entry_o.expiry = trip ? win_end : entry_i.expiry;

endmodule

`default_nettype wire

// File: hdl/fbt_table.sv
// Breaker state table: one entry per target and per (target, model) pair,
// model presence flags, and the clearing of one target or of all. Depends on fbt_pkg.
`default_nettype none

module fbt_table import fbt_pkg::*; #(
  parameter int TARGETS           = TARGETS_DEF,
  parameter int MODELS_PER_TARGET = MODELS_DEF,
  parameter int TIDX_W            = (TARGETS > 1) ? $clog2(TARGETS) : 1,
  parameter int KIDX_W            = (TARGETS * MODELS_PER_TARGET > 1) ?
                                    $clog2(TARGETS * MODELS_PER_TARGET) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [TIDX_W-1:0] t_idx_i,
  input  wire logic [KIDX_W-1:0] k_idx_i,
  input  wire fbt_wr_t           wr_i,
  output fbt_rd_t                rd_o
);

  localparam int ENTRIES = TARGETS * MODELS_PER_TARGET;

  fbt_entry_t tgt_q [TARGETS];
  fbt_entry_t mdl_q [ENTRIES];
  logic [ENTRIES-1:0] present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TARGETS; t++) begin
        tgt_q[t] <= '0;
      end
      for (int k = 0; k < ENTRIES; k++) begin
        mdl_q[k] <= '0;
      end
      present_q <= '0;
    end else if (wr_i.clear_all) begin
      for (int t = 0; t < TARGETS; t++) begin
        tgt_q[t] <= '0;
      end
      for (int k = 0; k < ENTRIES; k++) begin
        mdl_q[k] <= '0;
      end
      present_q <= '0;
    end else if (wr_i.forget) begin
      tgt_q[t_idx_i] <= '0;
      for (int m = 0; m < MODELS_PER_TARGET; m++) begin
        mdl_q[KIDX_W'(32'(t_idx_i) * MODELS_PER_TARGET + m)]     <= '0;
        present_q[KIDX_W'(32'(t_idx_i) * MODELS_PER_TARGET + m)] <= 1'b0;
      end
    end else begin
      if (wr_i.tgt_we) begin
        tgt_q[t_idx_i] <= wr_i.tgt;
      end
      if (wr_i.mdl_we) begin
        mdl_q[k_idx_i]     <= wr_i.mdl;
        present_q[k_idx_i] <= 1'b1;
      end
    end
  end

  always_comb begin
    rd_o.tgt         = tgt_q[t_idx_i];
    rd_o.mdl         = mdl_q[k_idx_i];
    rd_o.present     = present_q[k_idx_i];
    rd_o.any_present = 1'b0;
    for (int m = 0; m < MODELS_PER_TARGET; m++) begin
      rd_o.any_present = rd_o.any_present |
                         present_q[KIDX_W'(32'(t_idx_i) * MODELS_PER_TARGET + m)];
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the failure breaker table: directed words, then random phases.
// Depends on fbt_pkg and the failure_breaker_table top level, and through it on the other design files.
`timescale 1ns / 100ps

module tb;
  import fbt_pkg::*;

  localparam int          N_TARGETS   = 8;
  localparam int          N_MODELS    = 4;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          RANDOM_WORDS_PER_PHASE = 350;
  localparam int          LONG_RUN_WORDS = 260;
  localparam int          REPORT_LIMIT = 10;
  // The action field is three bits wide, so one code is left without a meaning.
  localparam logic [2:0]  ACT_UNUSED  = 3'd7;
  localparam logic [39:0] NOW_MAX     = 40'hFF_FFFF_FFFF;
  localparam logic [21:0] HINT_MAX    = 22'h3F_FFFF;

  // One command word as the sender offers it.
  typedef struct packed {
    logic [2:0]        act;
    logic [2:0]        tgt;
    logic [1:0]        mdl;
    logic [TIME_W-1:0] now;
    logic [HINT_W-1:0] hint;
  } breaker_word_t;

  // One result word, field for field as it leaves the block.
  typedef struct packed {
    logic               skipped;
    logic               mdl_window;
    logic               target_open;
    logic [RUN_W-1:0]   target_run;
    logic [RUN_W-1:0]   model_run;
    logic [TOTAL_W-1:0] target_total;
    logic [TOTAL_W-1:0] model_total;
    logic [1:0]         target_status;
    logic [1:0]         model_status;
  } breaker_result_t;

  // A row of the directed table: a word, and optionally the result typed in by hand.
  typedef struct packed {
    breaker_word_t   word;
    logic            fixed;
    breaker_result_t res;
  } directed_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [2:0]          action_i;
  logic [2:0]          target_index_i;
  logic [1:0]          model_index_i;
  logic [TIME_W-1:0]   now_ms_i;
  logic [HINT_W-1:0]   hint_ms_i;
  logic                done_o;
  logic                skipped_o;
  logic                model_open_o;
  logic                target_open_o;
  logic [RUN_W-1:0]    target_run_o;
  logic [RUN_W-1:0]    model_run_o;
  logic [TOTAL_W-1:0]  target_total_o;
  logic [TOTAL_W-1:0]  model_total_o;
  logic [1:0]          target_status_o;
  logic [1:0]          model_status_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  failure_breaker_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .target_index_i  (target_index_i),
    .model_index_i   (model_index_i),
    .now_ms_i        (now_ms_i),
    .hint_ms_i       (hint_ms_i),
    .done_o          (done_o),
    .skipped_o       (skipped_o),
    .model_open_o    (model_open_o),
    .target_open_o   (target_open_o),
    .target_run_o    (target_run_o),
    .model_run_o     (model_run_o),
    .target_total_o  (target_total_o),
    .model_total_o   (model_total_o),
    .target_status_o (target_status_o),
    .model_status_o  (model_status_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // The clock runs with a 12 ns period.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // The predictor's own copy of the registers and the breaker tables.
  logic [THR_W-1:0]  cfg_threshold;
  logic [HINT_W-1:0] cfg_cooldown;
  fbt_entry_t        target_tab [N_TARGETS];
  fbt_entry_t        model_tab  [N_TARGETS*N_MODELS];
  logic              model_known [N_TARGETS*N_MODELS];

  breaker_result_t   expected_results[$];
  directed_row_t     directed_rows[$];
  int                fault_count;
  int                cycle_count;
  int                burst_left;
  logic [TIME_W-1:0] clock_cursor_ms;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // One failure on a breaker entry. The window opens when a wait hint is given or the
  // run reaches the threshold, and its end is held at the largest time if it would wrap.
  function automatic fbt_entry_t trip_breaker(input fbt_entry_t e,
                                              input logic [TIME_W-1:0] now,
                                              input logic [HINT_W-1:0] hint);
    logic [HINT_W-1:0] hold_ms;
    logic [TIME_W:0]   open_end;
    e.run   = (e.run == '1) ? e.run : e.run + 1'b1;
    e.total = bump_total(e.total);
    e.st    = ST_DEGRADED;
    if (hint != '0 || e.run >= {8'd0, cfg_threshold}) begin
      hold_ms  = (cfg_cooldown > hint) ? cfg_cooldown : hint;
      open_end = {1'b0, now} + {19'd0, hold_ms};
      e.expiry = open_end[TIME_W] ? NOW_MAX : open_end[TIME_W-1:0];
      e.st     = ST_OPEN;
    end
    return e;
  endfunction

  function automatic void forget_target(input int t);
    target_tab[t] = '0;
    for (int j = 0; j < N_MODELS; j++) begin
      model_tab[t*N_MODELS+j]   = '0;
      model_known[t*N_MODELS+j] = 1'b0;
    end
  endfunction

  function automatic void settle_target(input int t);
    target_tab[t].run    = '0;
    target_tab[t].expiry = '0;
    target_tab[t].st     = ST_HEALTHY;
  endfunction

  // Applies one word to the table copy and returns the result that it should produce.
  function automatic breaker_result_t predict_breaker(input breaker_word_t w);
    int              t;
    int              k;
    logic            any_model;
    breaker_result_t r;
    t = int'(w.tgt);
    k = t * N_MODELS + int'(w.mdl);
    if (w.act == ACT_CLEAR_ALL) begin
      for (int j = 0; j < N_TARGETS; j++) forget_target(j);
    end
    case (w.act)
      ACT_TARGET_FAIL: begin
        target_tab[t] = trip_breaker(target_tab[t], w.now, w.hint);
      end
      ACT_MODEL_FAIL: begin
        // The target entry follows the model entry, but its total counts on its own.
        model_known[k]       = 1'b1;
        model_tab[k]         = trip_breaker(model_tab[k], w.now, w.hint);
        target_tab[t].run    = model_tab[k].run;
        target_tab[t].total  = bump_total(target_tab[t].total);
        target_tab[t].st     = model_tab[k].st;
        target_tab[t].expiry = model_tab[k].expiry;
      end
      ACT_TARGET_SUCCESS: begin
        settle_target(t);
      end
      ACT_MODEL_SUCCESS: begin
        model_known[k]      = 1'b1;
        model_tab[k].st     = ST_HEALTHY;
        model_tab[k].run    = '0;
        model_tab[k].expiry = '0;
        settle_target(t);
      end
      ACT_FORGET: begin
        forget_target(t);
      end
      default: begin
      end
    endcase
    any_model = 1'b0;
    for (int j = 0; j < N_MODELS; j++) any_model |= model_known[t*N_MODELS+j];
    r               = '0;
    r.mdl_window    = model_known[k] && (w.now < model_tab[k].expiry);
    r.target_open   = w.now < target_tab[t].expiry;
    // A query skips on a running model window, or on a running target window when the
    // target has never heard of any of its models.
    r.skipped       = (w.act == ACT_QUERY) && (r.mdl_window || (!any_model && r.target_open));
    r.target_run    = target_tab[t].run;
    r.model_run     = model_tab[k].run;
    r.target_total  = target_tab[t].total;
    r.model_total   = model_tab[k].total;
    r.target_status = target_tab[t].st;
    r.model_status  = model_tab[k].st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  function automatic string show_result(input breaker_result_t r);
    return $sformatf("skip=%0d mopen=%0d topen=%0d trun=%0d mrun=%0d ttot=%0d mtot=%0d tst=%0d mst=%0d",
                     r.skipped, r.mdl_window, r.target_open, r.target_run, r.model_run,
                     r.target_total, r.model_total, r.target_status, r.model_status);
  endfunction

  // Every result word is compared with the oldest outstanding expectation. The values read
  // here are those held during the cycle that this edge closes.
  always @(posedge clk_i) begin
    breaker_result_t got;
    breaker_result_t want;
    if (rst_ni && done_o) begin
      got = '{skipped_o, model_open_o, target_open_o, target_run_o, model_run_o,
              target_total_o, model_total_o, target_status_o, model_status_o};
      if (expected_results.size() == 0) begin
        note_fault($sformatf("unexpected result word: %s", show_result(got)));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          note_fault($sformatf("result mismatch\n  expected %s\n  actual   %s",
                               show_result(want), show_result(got)));
        end
      end
    end
  end

  // The run is abandoned if it goes on far longer than the slowest correct run could.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[failure_breaker_table] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------------------

  // Offers one word and holds it until the block takes it. Each call starts and ends at a
  // rising edge, so start is never lowered and raised within the same time step.
  task automatic send_word(input breaker_word_t w, input logic fixed,
                           input breaker_result_t fixed_res);
    breaker_result_t predicted;
    start          <= 1'b1;
    action_i       <= w.act;
    target_index_i <= w.tgt;
    model_index_i  <= w.mdl;
    now_ms_i       <= w.now;
    hint_ms_i      <= w.hint;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // The predictor must see every word, even where the result is typed in by hand.
    predicted = predict_breaker(w);
    expected_results.insert(expected_results.size(), fixed ? fixed_res : predicted);
  endtask

  // Between bursts of random length the sender falls silent.
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    burst_left--;
  endtask

  // Stops offering words until every expected result has arrived. Each word gives one
  // result, so nothing is still in flight once the queue has emptied.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------------------

  // A transfer has a setup phase and an access phase; an idle phase follows so that the
  // next transfer never lowers and raises psel in the same time step.
  task automatic apb_transfer(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(input logic idx, input logic [31:0] want);
    logic [31:0] rdata;
    apb_transfer(1'b0, idx, '0, rdata);
    if (rdata !== want) begin
      note_fault($sformatf("register %0d reads %0d, expected %0d", idx, rdata, want));
    end
  endtask

  // Writes both registers while the block is idle, then reads them back.
  task automatic set_breaker_config(input logic [THR_W-1:0] thr, input logic [HINT_W-1:0] cd);
    logic [31:0] unused;
    apb_transfer(1'b1, REG_THRESHOLD, {24'd0, thr}, unused);
    apb_transfer(1'b1, REG_COOLDOWN, {10'd0, cd}, unused);
    cfg_threshold = thr;
    cfg_cooldown  = cd;
    check_register(REG_THRESHOLD, {24'd0, thr});
    check_register(REG_COOLDOWN, {10'd0, cd});
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  function automatic breaker_result_t typed_result(
      input logic sk, input logic mo, input logic to,
      input logic [RUN_W-1:0] trun, input logic [RUN_W-1:0] mrun,
      input logic [TOTAL_W-1:0] ttot, input logic [TOTAL_W-1:0] mtot,
      input logic [1:0] tst, input logic [1:0] mst);
    return '{sk, mo, to, trun, mrun, ttot, mtot, tst, mst};
  endfunction

  task automatic add_row(input logic [2:0] act, input logic [2:0] tgt, input logic [1:0] mdl,
                         input logic [TIME_W-1:0] now, input logic [HINT_W-1:0] hint,
                         input logic fixed, input breaker_result_t res);
    directed_row_t row;
    row = '{'{act, tgt, mdl, now, hint}, fixed, res};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // The directed table runs with the register defaults: threshold 3, cooldown 30000.
  task automatic build_directed_rows();
    breaker_result_t none;
    none = '0;
    // Straight after reset every entry is empty.
    add_row(ACT_QUERY, 3'd0, 2'd0, 40'd0, 22'd0, 1'b1, none);
    // Three target failures in a row: degraded, then open at the threshold.
    add_row(ACT_TARGET_FAIL, 3'd1, 2'd0, 40'd1000, 22'd0, 1'b1,
            typed_result(1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 32'd1, 32'd0,
                         ST_DEGRADED, ST_HEALTHY));
    add_row(ACT_TARGET_FAIL, 3'd1, 2'd0, 40'd1000, 22'd0, 1'b0, none);
    add_row(ACT_TARGET_FAIL, 3'd1, 2'd0, 40'd1000, 22'd0, 1'b1,
            typed_result(1'b0, 1'b0, 1'b1, 16'd3, 16'd0, 32'd3, 32'd0,
                         ST_OPEN, ST_HEALTHY));
    // The target has no models, so its own window makes the query skip.
    add_row(ACT_QUERY, 3'd1, 2'd0, 40'd1000, 22'd0, 1'b1,
            typed_result(1'b1, 1'b0, 1'b1, 16'd3, 16'd0, 32'd3, 32'd0,
                         ST_OPEN, ST_HEALTHY));
    // At the very end of the window it no longer runs.
    add_row(ACT_QUERY, 3'd1, 2'd3, 40'd31000, 22'd0, 1'b0, none);
    // A hint longer than the cooldown opens the model at once and copies into the target.
    add_row(ACT_MODEL_FAIL, 3'd2, 2'd1, 40'd5000, 22'd100000, 1'b1,
            typed_result(1'b0, 1'b1, 1'b1, 16'd1, 16'd1, 32'd1, 32'd1,
                         ST_OPEN, ST_OPEN));
    add_row(ACT_QUERY, 3'd2, 2'd1, 40'd6000, 22'd0, 1'b0, none);
    // A sibling model is absent, but the target now has one, so no skip.
    add_row(ACT_QUERY, 3'd2, 2'd0, 40'd6000, 22'd0, 1'b0, none);
    add_row(ACT_MODEL_SUCCESS, 3'd2, 2'd1, 40'd7000, 22'd0, 1'b0, none);
    add_row(ACT_TARGET_SUCCESS, 3'd1, 2'd2, 40'd0, 22'd0, 1'b0, none);
    // A short hint still opens for the full cooldown.
    add_row(ACT_TARGET_FAIL, 3'd6, 2'd2, 40'd20, 22'd1, 1'b0, none);
    add_row(ACT_QUERY, 3'd6, 2'd2, 40'd30019, 22'd0, 1'b0, none);
    // The window end saturates at the largest time instead of wrapping.
    add_row(ACT_TARGET_FAIL, 3'd3, 2'd2, NOW_MAX - 40'd10, HINT_MAX, 1'b0, none);
    add_row(ACT_QUERY, 3'd3, 2'd2, NOW_MAX - 40'd1, 22'd0, 1'b0, none);
    add_row(ACT_QUERY, 3'd3, 2'd2, NOW_MAX, 22'd0, 1'b0, none);
    add_row(ACT_MODEL_FAIL, 3'd3, 2'd3, NOW_MAX, HINT_MAX, 1'b0, none);
    // The unused action code only reports the state.
    add_row(ACT_UNUSED, 3'd3, 2'd3, 40'd0, HINT_MAX, 1'b0, none);
    // Forget wipes the target and all of its models.
    add_row(ACT_FORGET, 3'd2, 2'd1, 40'd0, 22'd0, 1'b1, none);
    add_row(ACT_MODEL_FAIL, 3'd4, 2'd3, 40'd0, 22'd0, 1'b0, none);
    add_row(ACT_MODEL_SUCCESS, 3'd7, 2'd0, 40'd100, 22'd0, 1'b0, none);
    // Clear all wipes every target, whichever one the word names.
    add_row(ACT_CLEAR_ALL, 3'd5, 2'd0, 40'd0, 22'd0, 1'b1, none);
    add_row(ACT_QUERY, 3'd4, 2'd3, 40'd0, 22'd0, 1'b0, none);
    add_row(ACT_QUERY, 3'd3, 2'd3, NOW_MAX, 22'd0, 1'b1, none);
  endtask

  // Times mostly march forward from a cursor so that windows open, run and close; now and
  // then a time is far off, wholly random or close to the largest value.
  function automatic logic [TIME_W-1:0] pick_now();
    logic [63:0] wide;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      wide = {$urandom, $urandom};
      return wide[TIME_W-1:0];
    end else if (r < 5) begin
      return NOW_MAX - TIME_W'($urandom_range(0, 5000000));
    end
    if (r < 10) clock_cursor_ms += TIME_W'($urandom_range(0, 400000));
    else        clock_cursor_ms += TIME_W'($urandom_range(0, 2000));
    return clock_cursor_ms;
  endfunction

  function automatic logic [HINT_W-1:0] pick_hint();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      return '0;
    else if (r < 90) return HINT_W'($urandom_range(1, 100000));
    else if (r < 95) return HINT_W'($urandom_range(0, 4194303));
    return HINT_MAX;
  endfunction

  // Failures and queries dominate, on a few busy targets, so runs build up to the threshold.
  function automatic breaker_word_t pick_word();
    breaker_word_t w;
    int            r;
    r = $urandom_range(0, 99);
    if (r < 25)      w.act = ACT_TARGET_FAIL;
    else if (r < 45) w.act = ACT_MODEL_FAIL;
    else if (r < 55) w.act = ACT_TARGET_SUCCESS;
    else if (r < 65) w.act = ACT_MODEL_SUCCESS;
    else if (r < 90) w.act = ACT_QUERY;
    else if (r < 95) w.act = ACT_FORGET;
    else if (r < 97) w.act = ACT_CLEAR_ALL;
    else             w.act = ACT_UNUSED;
    w.tgt  = ($urandom_range(0, 99) < 70) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
    w.mdl  = 2'($urandom_range(0, 3));
    w.now  = pick_now();
    w.hint = pick_hint();
    return w;
  endfunction

  task automatic run_random_phase(input int words);
    for (int i = 0; i < words; i++) begin
      send_word(pick_word(), 1'b0, '0);
      // Once in a while the sender waits for every outstanding result.
      if ($urandom_range(0, 199) == 0) begin
        drain_results();
        burst_left = 0;
      end else begin
        pace_sender();
      end
    end
    drain_results();
  endtask

  // Drives one model back to back through a run of failures long enough to cross the
  // largest threshold.
  task automatic run_long_burst();
    breaker_word_t w;
    w = '{ACT_MODEL_FAIL, 3'd7, 2'd3, clock_cursor_ms, 22'd0};
    for (int i = 0; i < LONG_RUN_WORDS; i++) send_word(w, 1'b0, '0);
    w.act = ACT_QUERY;
    send_word(w, 1'b0, '0);
    drain_results();
  endtask

  initial begin
    logic [THR_W-1:0]  thr_pick;
    logic [HINT_W-1:0] cd_pick;
    fault_count     = 0;
    cycle_count     = 0;
    burst_left      = 0;
    cfg_threshold   = THRESHOLD_RST;
    cfg_cooldown    = COOLDOWN_RST;
    clock_cursor_ms = TIME_W'($urandom);
    for (int j = 0; j < N_TARGETS; j++) forget_target(j);
    // Every input is known from the first instant of the run.
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    action_i       <= ACT_QUERY;
    target_index_i <= '0;
    model_index_i  <= '0;
    now_ms_i       <= '0;
    hint_ms_i      <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The registers come out of reset with their defaults.
    check_register(REG_THRESHOLD, {24'd0, THRESHOLD_RST});
    check_register(REG_COOLDOWN, {10'd0, COOLDOWN_RST});

    build_directed_rows();
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].res);
      pace_sender();
    end
    drain_results();

    // Random phases over the register extremes; a threshold of zero trips on every failure.
    set_breaker_config(8'd0, 22'd0);
    run_random_phase(RANDOM_WORDS_PER_PHASE);
    set_breaker_config(8'd255, 22'd3600000);
    run_long_burst();
    run_random_phase(RANDOM_WORDS_PER_PHASE);
    set_breaker_config(8'd1, HINT_MAX);
    run_random_phase(RANDOM_WORDS_PER_PHASE);
    thr_pick = THR_W'($urandom_range(1, 255));
    cd_pick  = HINT_W'($urandom_range(0, 3600000));
    set_breaker_config(thr_pick, cd_pick);
    run_random_phase(RANDOM_WORDS_PER_PHASE);
    set_breaker_config(8'd2, 22'd500);
    run_random_phase(RANDOM_WORDS_PER_PHASE);

    // Wait on past the last expected result in case the block produces a word nobody asked for.
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (expected_results.size() != 0) note_fault("expected results left over at the end");

    if (fault_count == 0) begin
      $display("[failure_breaker_table] OK");
    end else begin
      $display("[failure_breaker_table] ERROR");
    end
    $finish;
  end

endmodule
